@@ design/png_scanline_unfilter_defines.svh @@
// Assertion macros shared by the scanline unfilter modules.
// Depends on nothing; the checks compile away when SYNTH is defined.
`ifndef PNG_SCANLINE_UNFILTER_DEFINES_SVH
`define PNG_SCANLINE_UNFILTER_DEFINES_SVH
`ifndef SYNTH
`define PSU_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define PSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PSU_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define PSU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ design/psu_pkg.sv @@
// Types and constants of the scanline unfilter: beat structs, queue entry,
// filter codes and Adam7 pass geometry. Depends on nothing.
package psu_pkg;

    localparam int IDX_W = 20;

    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    localparam logic [2:0] PASS_WHOLE = 3'd7;

    localparam logic [1:0] REG_WIDTH      = 2'd0;
    localparam logic [1:0] REG_HEIGHT     = 2'd1;
    localparam logic [1:0] REG_BPP        = 2'd2;
    localparam logic [1:0] REG_INTERLACED = 2'd3;

    localparam logic [3:0] ORG_X [8] = '{4'd0, 4'd4, 4'd0, 4'd2, 4'd0, 4'd1, 4'd0, 4'd0};
    localparam logic [3:0] ORG_Y [8] = '{4'd0, 4'd0, 4'd4, 4'd0, 4'd2, 4'd0, 4'd1, 4'd0};
    localparam logic [3:0] STEP_X [8] = '{4'd8, 4'd8, 4'd4, 4'd4, 4'd2, 4'd2, 4'd1, 4'd1};
    localparam logic [3:0] STEP_Y [8] = '{4'd8, 4'd8, 4'd8, 4'd4, 4'd4, 4'd2, 4'd2, 4'd1};
    localparam logic [1:0] SHIFT_X [8] = '{2'd3, 2'd3, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0};
    localparam logic [1:0] SHIFT_Y [8] = '{2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0};

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  pixel_byte;
        logic [2:0]  pass_number;
        logic [11:0] row_in_pass;
        logic [14:0] byte_in_row;
        logic        row_end;
        logic        image_end;
        logic        bad_filter;
    } out_item_t;

    typedef struct packed {
        logic             bad;
        logic             first_row;
        logic             stored;
        logic [2:0]       ftype;
        logic [7:0]       data;
        logic [IDX_W-1:0] idx;
        logic [2:0]       pass_number;
        logic [11:0]      row;
        logic             row_end;
        logic             image_end;
    } job_t;

endpackage

@@ design/psu_front.sv @@
// Front part: accepts stream beats, tracks filter bytes, rows and Adam7 passes,
// and queues one job per result. Depends on psu_pkg.
module psu_front #(
    parameter int MAX_DIM       = 4096,
    parameter int MAX_ROW_BYTES = 32768
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  psu_pkg::in_item_t item,
    output logic             item_stall,
    input  logic [12:0]      image_width,
    input  logic [12:0]      image_height,
    input  logic [6:0]       bpp_eff,
    input  logic             interlaced,
    output logic             push,
    output psu_pkg::job_t    job,
    input  logic             queue_ready
);
    import psu_pkg::*;

    logic [2:0]       pass_reg, pass_next;
    logic [12:0]      rows_reg, rows_next;
    logic [16:0]      rb_reg, rb_next;
    logic [12:0]      row_reg, row_next;
    logic [IDX_W-1:0] bc_reg, bc_next;
    logic [2:0]       ftype_reg, ftype_next;
    logic             first_reg, first_next;
    logic             done_reg, done_next;
    logic             err_reg, err_next;

    logic        accept;
    logic [12:0] w, h;
    logic [3:0]  bp_start;
    logic [12:0] pw_all [8];
    logic [12:0] ph_all [8];
    logic        bp_found;
    logic [2:0]  bp_sel;
    logic [19:0] rb_prod;
    logic [16:0] bp_rb;
    logic [2:0]  pnum;
    logic [12:0] row_inc;

    assign item_stall = !queue_ready;
    assign accept     = item_valid && queue_ready;
    assign w = (32'(image_width) > MAX_DIM) ? 13'(MAX_DIM) : image_width;
    assign h = (32'(image_height) > MAX_DIM) ? 13'(MAX_DIM) : image_height;
    assign bp_start = item.kind ? 4'd0 : {1'b0, pass_reg} + 4'd1;
    assign pnum = interlaced ? pass_reg : PASS_WHOLE;
    assign row_inc = row_reg + 13'd1;

    always_comb
    begin
        bp_found = 1'b0;
        bp_sel   = PASS_WHOLE;
        for (int q = 0; q < 8; q++)
        begin
            pw_all[q] = (w > 13'(ORG_X[q])) ?
                13'((14'(w) - 14'(ORG_X[q]) + 14'(STEP_X[q]) - 14'd1) >> SHIFT_X[q]) : 13'd0;
            ph_all[q] = (h > 13'(ORG_Y[q])) ?
                13'((14'(h) - 14'(ORG_Y[q]) + 14'(STEP_Y[q]) - 14'd1) >> SHIFT_Y[q]) : 13'd0;
        end
        for (int q = 7; q >= 0; q--)
        begin
            if (pw_all[q] != 13'd0 && ph_all[q] != 13'd0 && 4'(q) >= bp_start &&
                (interlaced ? (q <= 6) : (q == 7)))
            begin
                bp_found = 1'b1;
                bp_sel   = 3'(q);
            end
        end
        rb_prod = 20'(pw_all[bp_sel]) * 20'(bpp_eff);
        bp_rb   = 17'((rb_prod + 20'd7) >> 3);
    end

    always_comb
    begin
        pass_next  = pass_reg;
        rows_next  = rows_reg;
        rb_next    = rb_reg;
        row_next   = row_reg;
        bc_next    = bc_reg;
        ftype_next = ftype_reg;
        first_next = first_reg;
        done_next  = done_reg;
        err_next   = err_reg;
        push       = 1'b0;
        job.bad         = 1'b0;
        job.first_row   = first_reg;
        job.stored      = (32'(bc_reg - 20'd1) < MAX_ROW_BYTES);
        job.ftype       = ftype_reg;
        job.data        = item.data_byte;
        job.idx         = bc_reg - 20'd1;
        job.pass_number = pnum;
        job.row         = row_reg[11:0];
        job.row_end     = 1'b0;
        job.image_end   = 1'b0;
        if (accept)
        begin
            if (item.kind)
            begin
                err_next  = 1'b0;
                done_next = !bp_found;
                if (bp_found)
                begin
                    pass_next  = bp_sel;
                    rows_next  = ph_all[bp_sel];
                    rb_next    = bp_rb;
                    row_next   = 13'd0;
                    bc_next    = '0;
                    first_next = 1'b1;
                end
            end
            else if (!done_reg && !err_reg)
            begin
                if (bc_reg == '0)
                begin
                    if (item.data_byte > 8'd4)
                    begin
                        err_next = 1'b1;
                        push     = 1'b1;
                        job.bad  = 1'b1;
                        job.idx  = '0;
                    end
                    else
                    begin
                        ftype_next = item.data_byte[2:0];
                        bc_next    = 20'd1;
                    end
                end
                else
                begin
                    push    = 1'b1;
                    bc_next = bc_reg + 20'd1;
                    if (bc_reg >= 20'(rb_reg))
                    begin
                        job.row_end = 1'b1;
                        bc_next     = '0;
                        first_next  = 1'b0;
                        row_next    = row_inc;
                        if (row_inc >= rows_reg)
                        begin
                            if (bp_found)
                            begin
                                pass_next  = bp_sel;
                                rows_next  = ph_all[bp_sel];
                                rb_next    = bp_rb;
                                row_next   = 13'd0;
                                first_next = 1'b1;
                            end
                            else
                            begin
                                done_next     = 1'b1;
                                job.image_end = 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_reg  <= '0;
            rows_reg  <= '0;
            rb_reg    <= '0;
            row_reg   <= '0;
            bc_reg    <= '0;
            ftype_reg <= '0;
            first_reg <= 1'b1;
            done_reg  <= 1'b1;
            err_reg   <= 1'b0;
        end
        else
        begin
            pass_reg  <= pass_next;
            rows_reg  <= rows_next;
            rb_reg    <= rb_next;
            row_reg   <= row_next;
            bc_reg    <= bc_next;
            ftype_reg <= ftype_next;
            first_reg <= first_next;
            done_reg  <= done_next;
            err_reg   <= err_next;
        end
    end

endmodule

@@ design/psu_queue.sv @@
// Two-entry job queue between the front and back parts.
// Depends on psu_pkg and the assertion macro header.
`include "png_scanline_unfilter_defines.svh"
module psu_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  psu_pkg::job_t push_job,
    output logic          ready,
    input  logic          pop,
    output logic          head_valid,
    output psu_pkg::job_t head_job
);
    import psu_pkg::*;

    job_t       slot_reg [2];
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic [1:0] count_reg, count_next;

    assign ready      = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_job   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ pop;
        wr_ptr_next = wr_ptr_reg ^ push;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    `PSU_ASSERT_ALWAYS(a_count_range, clk, rst_n, count_reg <= 2'd2)
    `PSU_ASSERT_ALWAYS(a_no_overflow, clk, rst_n, !(push && count_reg == 2'd2))
    `PSU_ASSERT_ALWAYS(a_no_underflow, clk, rst_n, !(pop && count_reg == 2'd0))
    `PSU_ASSERT_NEXT(a_ptr_track, clk, rst_n, count_reg == 2'd0 && !push,
        rd_ptr_reg == wr_ptr_reg)

endmodule

@@ design/psu_back.sv @@
// Back part: row store read, filter reconstruction and result register.
// Depends on psu_pkg and the assertion macro header.
`include "png_scanline_unfilter_defines.svh"
module psu_back #(
    parameter int MAX_ROW_BYTES = 32768
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  psu_pkg::job_t     head_job,
    output logic              pop,
    input  logic [3:0]        unit_bytes,
    output logic              result_valid,
    output psu_pkg::out_item_t result,
    input  logic              result_stall
);
    import psu_pkg::*;

    localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

    logic [7:0]  mem [MAX_ROW_BYTES];
    logic [7:0]  rdata_reg;
    logic        fwd_reg;
    logic [7:0]  fwd_data_reg;
    job_t        s1_reg;
    logic        s1_valid_reg, s1_valid_next;
    logic [63:0] left_reg, upleft_reg;
    logic        out_valid_reg;
    out_item_t   out_reg;

    logic        s1_adv, wr_en;
    logic [7:0]  a, b, c, pick, r;
    logic [5:0]  sh;
    logic [63:0] la, lc;
    logic signed [9:0] pa, pb, pc, dac, dbc;

    assign s1_adv = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign pop    = head_valid && (!s1_valid_reg || s1_adv);
    assign wr_en  = s1_adv && !s1_reg.bad && s1_reg.stored;
    assign s1_valid_next = pop ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign result_valid = out_valid_reg;
    assign result = out_reg;

    always_comb
    begin
        sh = {3'(unit_bytes - 4'd1), 3'b000};
        la = left_reg >> sh;
        lc = upleft_reg >> sh;
        b  = (!s1_reg.first_row && s1_reg.stored) ? (fwd_reg ? fwd_data_reg : rdata_reg) : 8'd0;
        a  = (s1_reg.idx >= 20'(unit_bytes)) ? la[7:0] : 8'd0;
        c  = (s1_reg.idx >= 20'(unit_bytes)) ? lc[7:0] : 8'd0;
        dac = 10'(a) - 10'(c);
        dbc = 10'(b) - 10'(c);
        pa = (dbc < 0) ? -dbc : dbc;
        pb = (dac < 0) ? -dac : dac;
        pc = ((dac + dbc) < 0) ? -(dac + dbc) : (dac + dbc);
        if (pa <= pb && pa <= pc)
        begin
            pick = a;
        end
        else if (pb <= pc)
        begin
            pick = b;
        end
        else
        begin
            pick = c;
        end
        case (s1_reg.ftype)
            FILT_SUB:   r = s1_reg.data + a;
            FILT_UP:    r = s1_reg.data + b;
            FILT_AVG:   r = s1_reg.data + 8'((9'(a) + 9'(b)) >> 1);
            FILT_PAETH: r = s1_reg.data + pick;
            default:    r = s1_reg.data;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[s1_reg.idx[AW-1:0]] <= r;
        end
        if (pop)
        begin
            rdata_reg    <= mem[head_job.idx[AW-1:0]];
            s1_reg       <= head_job;
            fwd_data_reg <= r;
        end
        if (s1_adv)
        begin
            out_reg.pixel_byte  <= s1_reg.bad ? 8'd0 : r;
            out_reg.pass_number <= s1_reg.pass_number;
            out_reg.row_in_pass <= s1_reg.row;
            out_reg.byte_in_row <= s1_reg.idx[14:0];
            out_reg.row_end     <= s1_reg.row_end;
            out_reg.image_end   <= s1_reg.image_end;
            out_reg.bad_filter  <= s1_reg.bad;
        end
        if (s1_adv && !s1_reg.bad)
        begin
            left_reg   <= {left_reg[55:0], r};
            upleft_reg <= {upleft_reg[55:0], b};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (pop)
            begin
                fwd_reg <= wr_en && (head_job.idx[AW-1:0] == s1_reg.idx[AW-1:0]);
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `PSU_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid_reg && result_stall,
        out_valid_reg && $stable(out_reg))
    `PSU_ASSERT_ALWAYS(a_write_needs_stage, clk, rst_n, !wr_en || s1_valid_reg)
    `PSU_ASSERT_NEXT(a_pop_fills_stage, clk, rst_n, pop, s1_valid_reg)

endmodule

@@ design/png_scanline_unfilter.sv @@
// PNG scanline unfilter top level: configuration registers, front, queue, back.
// Depends on psu_pkg, psu_front, psu_queue and psu_back.
//
// The block takes one inflated stream byte per clock while item_stall is low.
// The job of each reconstructed byte is written into the job queue; the row
// store is read as the job is popped into the filter stage, and the result
// register is loaded from that stage. A valid filter type byte or an ignored
// byte gives no result. The rate of one byte per cycle, when nothing stalls,
// rests on the row store, which is read for one byte while the previous byte
// is written back.
module png_scanline_unfilter #(
    parameter int MAX_DIM       = 4096,
    parameter int MAX_ROW_BYTES = 32768
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  psu_pkg::in_item_t  item,
    output logic               item_stall,
    output logic               result_valid,
    output psu_pkg::out_item_t result,
    input  logic               result_stall,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [12:0]        cfg_data
);
    import psu_pkg::*;

    logic [12:0] width_reg, height_reg;
    logic [6:0]  bpp_reg;
    logic        interlaced_reg;
    logic [6:0]  bpp_eff;
    logic [3:0]  unit_raw, unit_bytes;
    logic        push, queue_ready, pop, head_valid;
    job_t        push_job, head_job;

    assign bpp_eff    = (bpp_reg == 7'd0) ? 7'd1 : bpp_reg;
    assign unit_raw   = bpp_eff[6:3];
    assign unit_bytes = (unit_raw == 4'd0) ? 4'd1 : ((unit_raw > 4'd8) ? 4'd8 : unit_raw);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= 13'd1;
            height_reg     <= 13'd1;
            bpp_reg        <= 7'd8;
            interlaced_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:      width_reg      <= cfg_data;
                REG_HEIGHT:     height_reg     <= cfg_data;
                REG_BPP:        bpp_reg        <= cfg_data[6:0];
                REG_INTERLACED: interlaced_reg <= cfg_data[0];
                default:        width_reg      <= width_reg;
            endcase
        end
    end

    psu_front #(
        .MAX_DIM       (MAX_DIM),
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .item_stall   (item_stall),
        .image_width  (width_reg),
        .image_height (height_reg),
        .bpp_eff      (bpp_eff),
        .interlaced   (interlaced_reg),
        .push         (push),
        .job          (push_job),
        .queue_ready  (queue_ready)
    );

    psu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .ready      (queue_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    psu_back #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_job     (head_job),
        .pop          (pop),
        .unit_bytes   (unit_bytes),
        .result_valid (result_valid),
        .result       (result),
        .result_stall (result_stall)
    );

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for png_scanline_unfilter: a scoreboard class predicts
// each reconstructed byte and checks every result beat in order.
// Depends on psu_pkg and the png_scanline_unfilter RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import psu_pkg::*;

    localparam int ROW_STORE_BYTES = 32768;
    localparam int DIM_LIMIT = 4096;

    class scanline_scoreboard;
        int unsigned width_reg, height_reg, bpp_reg;
        bit interlace_reg;
        byte unsigned prev_row [ROW_STORE_BYTES];
        logic [63:0] left_hist, upleft_hist;
        int unsigned pass_idx, cols, rows, row_bytes, row_cnt, byte_cnt;
        logic [2:0] ftype;
        bit first_row, done, stopped;
        out_item_t pending [$];
        int errors, checked, bad_seen, starts;

        function new();
            width_reg = 1;
            height_reg = 1;
            bpp_reg = 8;
            interlace_reg = 0;
            left_hist = '0;
            upleft_hist = '0;
            pass_idx = 0;
            cols = 0;
            rows = 0;
            row_bytes = 0;
            row_cnt = 0;
            byte_cnt = 0;
            ftype = FILT_NONE;
            first_row = 1;
            done = 1;
            stopped = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [12:0] val);
            case (idx)
                REG_WIDTH: width_reg = val;
                REG_HEIGHT: height_reg = val;
                REG_BPP: bpp_reg = val[6:0];
                REG_INTERLACED: interlace_reg = val[0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_bpp();
            return (bpp_reg == 0) ? 1 : bpp_reg;
        endfunction

        function bit enter_pass(int unsigned first_pass);
            int unsigned w, h, p, last, pw, ph;
            w = (width_reg > DIM_LIMIT) ? DIM_LIMIT : width_reg;
            h = (height_reg > DIM_LIMIT) ? DIM_LIMIT : height_reg;
            last = interlace_reg ? 6 : 7;
            p = (!interlace_reg && first_pass < 7) ? 7 : first_pass;
            for (; p <= last; p++)
            begin
                pw = (w > ORG_X[p]) ? (w - ORG_X[p] + STEP_X[p] - 1) / STEP_X[p] : 0;
                ph = (h > ORG_Y[p]) ? (h - ORG_Y[p] + STEP_Y[p] - 1) / STEP_Y[p] : 0;
                if (pw != 0 && ph != 0)
                begin
                    pass_idx = p;
                    cols = pw;
                    rows = ph;
                    row_bytes = (pw * eff_bpp() + 7) / 8;
                    row_cnt = 0;
                    byte_cnt = 0;
                    first_row = 1;
                    return 1;
                end
            end
            return 0;
        endfunction

        function int unsigned paeth(int a, int b, int c);
            int p, pa, pb, pc;
            p = a + b - c;
            pa = (p > a) ? p - a : a - p;
            pb = (p > b) ? p - b : b - p;
            pc = (p > c) ? p - c : c - p;
            if (pa <= pb && pa <= pc)
                return a;
            if (pb <= pc)
                return b;
            return c;
        endfunction

        function void note_beat(in_item_t beat);
            int unsigned i, fu, a, b, c, r, pnum, d;
            out_item_t o;
            d = beat.data_byte;
            if (beat.kind)
            begin
                stopped = 0;
                left_hist = '0;
                upleft_hist = '0;
                done = !enter_pass(0);
                starts++;
                return;
            end
            if (done || stopped)
                return;
            pnum = interlace_reg ? pass_idx : PASS_WHOLE;
            o = '0;
            o.pass_number = pnum[2:0];
            o.row_in_pass = row_cnt[11:0];
            if (byte_cnt == 0)
            begin
                if (d > FILT_PAETH)
                begin
                    stopped = 1;
                    o.bad_filter = 1;
                    pending.push_back(o);
                    bad_seen++;
                    return;
                end
                ftype = d[2:0];
                byte_cnt = 1;
                left_hist = '0;
                upleft_hist = '0;
                return;
            end
            i = byte_cnt - 1;
            fu = eff_bpp() / 8;
            if (fu < 1)
                fu = 1;
            if (fu > 8)
                fu = 8;
            b = (!first_row && i < ROW_STORE_BYTES) ? prev_row[i] : 0;
            a = (i >= fu) ? 32'((left_hist >> (8 * (fu - 1))) & 64'hFF) : 0;
            c = (i >= fu) ? 32'((upleft_hist >> (8 * (fu - 1))) & 64'hFF) : 0;
            case (ftype)
                FILT_SUB: r = d + a;
                FILT_UP: r = d + b;
                FILT_AVG: r = d + ((a + b) >> 1);
                FILT_PAETH: r = d + paeth(a, b, c);
                default: r = d;
            endcase
            r = r & 32'hFF;
            if (i < ROW_STORE_BYTES)
                prev_row[i] = r[7:0];
            left_hist = (left_hist << 8) | 64'(r);
            upleft_hist = (upleft_hist << 8) | 64'(b);
            o.pixel_byte = r[7:0];
            o.byte_in_row = i[14:0];
            byte_cnt++;
            if (byte_cnt >= row_bytes + 1)
            begin
                o.row_end = 1;
                byte_cnt = 0;
                first_row = 0;
                row_cnt++;
                if (row_cnt >= rows && !enter_pass(pass_idx + 1))
                begin
                    done = 1;
                    o.image_end = 1;
                end
            end
            pending.push_back(o);
        endfunction

        function void report(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endfunction

        function void compare_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                report($sformatf("%s got %0d expected %0d (result %0d)",
                    name, got, want, checked));
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result beat %h", got));
                return;
            end
            want = pending.pop_front();
            compare_field("pixel_byte", got.pixel_byte, want.pixel_byte);
            compare_field("pass_number", got.pass_number, want.pass_number);
            compare_field("row_in_pass", got.row_in_pass, want.row_in_pass);
            compare_field("byte_in_row", got.byte_in_row, want.byte_in_row);
            compare_field("row_end", got.row_end, want.row_end);
            compare_field("image_end", got.image_end, want.image_end);
            compare_field("bad_filter", got.bad_filter, want.bad_filter);
            checked++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic item_valid;
    in_item_t item;
    logic item_stall;
    logic result_valid;
    out_item_t result;
    logic result_stall;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [12:0] cfg_data;

    scanline_scoreboard sb = new();
    int unsigned cycle_count;
    int unsigned hold_left;
    int unsigned burst_left;
    int unsigned random_beats;

    png_scanline_unfilter i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item(item),
        .item_stall(item_stall),
        .result_valid(result_valid),
        .result(result),
        .result_stall(result_stall),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Receiver: checks accepted beats and stalls on a rotating pattern.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            case ((cycle_count / 97) % 4)
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom_range(0, 3) == 0);
                2: result_stall <= ($urandom_range(0, 9) < 7);
                default: result_stall <= (cycle_count % 5 == 0);
            endcase
        end
    end

    initial
    begin
        #4_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    task automatic send(input in_item_t beat);
        item_valid <= 1'b1;
        item <= beat;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_beat(beat);
        random_beats++;
        if (burst_left != 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0)
            begin
                item_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] d);
        in_item_t beat;
        beat.kind = 1'b0;
        beat.data_byte = d;
        send(beat);
    endtask

    task automatic send_start();
        in_item_t beat;
        beat.kind = 1'b1;
        beat.data_byte = 8'($urandom_range(0, 255));
        send(beat);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h,
                                input int unsigned bpp, input bit intl);
        drain();
        write_reg(REG_WIDTH, 13'(w));
        write_reg(REG_HEIGHT, 13'(h));
        write_reg(REG_BPP, 13'(bpp));
        write_reg(REG_INTERLACED, 13'(intl));
    endtask

    // Sends one well-formed image with random content, with rare noise:
    // a bad filter type or a restart early in the image; from beat abort_after on, every filter type byte is bad.
    task automatic send_image(input int unsigned abort_after);
        int unsigned n;
        logic [7:0] d;
        n = 0;
        send_start();
        while (!sb.done && !sb.stopped)
        begin
            if (sb.byte_cnt == 0)
            begin
                if (n >= abort_after || $urandom_range(0, 99) < 2)
                    d = 8'($urandom_range(FILT_PAETH + 1, 255));
                else
                    d = 8'($urandom_range(FILT_NONE, FILT_PAETH));
                send_byte(d);
            end
            else if (n < 1000 && $urandom_range(0, 599) == 0)
                send_start();
            else
            begin
                case ($urandom_range(0, 9))
                    0: d = 8'h00;
                    1: d = 8'hFF;
                    default: d = 8'($urandom_range(0, 255));
                endcase
                send_byte(d);
            end
            n++;
        end
        repeat ($urandom_range(0, 2))
            send_byte(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int unsigned k, w, h, bpp;
        int unsigned bpp_list [9] = '{1, 2, 4, 8, 16, 24, 32, 48, 64};
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_WIDTH;
        cfg_data = '0;
        cycle_count = 0;
        hold_left = 0;
        burst_left = 0;
        random_beats = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'h5A);
        send_start();
        send_byte(8'(FILT_NONE));
        send_byte(8'hFF);
        send_byte(8'h00);
        set_geometry(3, 4, 8, 0);
        send_start();
        send_byte(8'(FILT_SUB));
        send_byte(8'd10);
        send_byte(8'd20);
        send_byte(8'd30);
        send_byte(8'(FILT_UP));
        send_byte(8'd1);
        send_byte(8'd2);
        send_byte(8'd3);
        send_byte(8'(FILT_PAETH));
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'hFE);
        send_byte(8'(FILT_AVG));
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(8'h40);
        send_start();
        send_byte(8'd5);
        send_byte(8'h33);

        random_beats = 0;
        k = 0;
        while (random_beats < 1400)
        begin
            case (k)
                3: set_geometry(8191, 1, 1, 0);
                6: set_geometry(1, 8191, 1, 1);
                9: set_geometry(4096, 1, 64, 0);
                12: set_geometry(0, 5, 8, 1);
                15: set_geometry(5, 5, 0, 1);
                18: set_geometry(7, 3, 127, 0);
                21: set_geometry(1, 1, 8, 1);
                default:
                begin
                    w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                    : $urandom_range(1, 12);
                    h = $urandom_range(1, 9);
                    bpp = bpp_list[$urandom_range(0, 8)];
                    set_geometry(w, h, bpp, 1'($urandom_range(0, 1)));
                end
            endcase
            if (k == 1)
                hold_left = 400;
            if (k == 3 || k == 6 || k == 9)
            begin
                w = random_beats;
                send_image(k == 6 ? 300 : 32'hFFFF_FFFF);
                random_beats = w;
            end
            else
                repeat ($urandom_range(1, 3))
                    send_image(32'hFFFF_FFFF);
            k++;
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d expected beats never arrived", sb.pending.size()));
        $display("Checked %0d result beats over %0d image starts and %0d settings;",
            sb.checked, sb.starts, k + 2);
        $display("%0d bad filter types flagged, with stalls, gaps and a long hold-off.",
            sb.bad_seen);
        if (sb.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule

@@ png_scanline_unfilter.f @@
+incdir+design
design/psu_pkg.sv
design/psu_front.sv
design/psu_queue.sv
design/psu_back.sv
design/png_scanline_unfilter.sv
test/testbench.sv
